>>> design/bhs_pkg.sv
// Package for the bucketed hash set: key widths, action codes, controller
// states and the command and status records between controller and datapath.
// No dependencies.
package bhs_pkg;

    localparam int KEY_W      = 64;
    localparam int KEY_SHIFT  = 2;
    localparam int DIGIT_W    = 8;
    localparam int NUM_DIGITS = KEY_W / DIGIT_W;
    localparam int CNT_W      = $clog2(NUM_DIGITS);

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_TEST   = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_CMP,
        S_WRITE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_item;
        logic mod_step;
        logic clr_en;
        logic rd_en;
        logic cmp_en;
        logic wr_en;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic mod_last;
        logic out_free;
    } t_sts;

endpackage

>>> design/bhs_if.sv
// Channel interfaces of the bucketed hash set: request beats and result beats.
// Depends on bhs_pkg for the key width.
interface bhs_in_if import bhs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             action;
    logic [KEY_W-1:0] key;

    modport source (output valid, output action, output key, input ready);
    modport sink (input valid, input action, input key, output ready);
endinterface

interface bhs_out_if ();
    logic valid;
    logic ready;
    logic ok;

    modport source (output valid, output ok, input ready);
    modport sink (input valid, input ok, output ready);
endinterface

>>> design/bucketed_hash_set.sv
// Top level of the bucketed hash set: set of 64-bit keys in fixed buckets.
// Depends on bhs_pkg, bhs_if, bhs_dp and bhs_ctrl.
//
// Channel  Direction  Payload             Meaning of one beat
// i_in     in         action, key[63:0]   insert (0) or membership test (1)
// o_out    out        ok                  insert stored, present or key 0 / test found
//
// An item passes from acceptance through the byte-serial bucket index unit,
// then through row read, slot compare, row write and result load, in that
// order. The next item is accepted only after that result load, in idle.
// After reset the row memory is cleared one bucket per cycle, all NUM_BUCKETS
// buckets, before the first beat is accepted. A stalled result blocks only the
// result load of the following item.
module bucketed_hash_set import bhs_pkg::*; #(
    parameter int NUM_BUCKETS      = 19,
    parameter int SLOTS_PER_BUCKET = 8
) (
    input logic       i_clk,
    input logic       i_rst_n,
    bhs_in_if.sink    i_in,
    bhs_out_if.source o_out
);

    t_cmd cmd;
    t_sts sts;

    bhs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bhs_dp #(
        .NUM_BUCKETS      (NUM_BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_action (i_in.action),
        .i_in_key    (i_in.key),
        .o_out_valid (o_out.valid),
        .o_out_ok    (o_out.ok),
        .i_out_ready (o_out.ready)
    );

endmodule

>>> design/bhs_mod.sv
// Bucket index unit: reduces the shifted key modulo the bucket count, one
// byte per cycle, most significant byte first. Depends on bhs_pkg.
module bhs_mod import bhs_pkg::*; #(
    parameter int NUM_BUCKETS = 19,
    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_step,
    input  logic [KEY_W-1:0]       i_value,
    output logic                   o_last,
    output logic [BW-1:0]          o_rem
);

    localparam logic [BW:0] N_EXT = (BW + 1)'(NUM_BUCKETS);

    logic [KEY_W-1:0] r_val;
    logic [KEY_W-1:0] n_val;
    logic [BW-1:0]    r_rem;
    logic [BW-1:0]    n_rem;
    logic [CNT_W-1:0] r_cnt;
    logic [BW:0]      rem_acc;

    always_comb begin
        rem_acc = {1'b0, r_rem};
        for (int b = DIGIT_W - 1; b >= 0; b--) begin
            rem_acc = {rem_acc[BW-1:0], r_val[KEY_W-DIGIT_W+b]};
            if (rem_acc >= N_EXT) begin
                rem_acc = rem_acc - N_EXT;
            end
        end
        n_rem = rem_acc[BW-1:0];
        n_val = {r_val[KEY_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rem <= '0;
        end else if (i_start) begin
            r_cnt <= '0;
            r_rem <= '0;
        end else if (i_step) begin
            r_cnt <= r_cnt + 1'b1;
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
        end else if (i_step) begin
            r_val <= n_val;
        end
    end

    assign o_last = (r_cnt == CNT_W'(NUM_DIGITS - 1));
    assign o_rem  = r_rem;

`ifndef SYNTHESIS
    a_rem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_rem} < N_EXT)
        else $error("Bucket remainder is not below the bucket count.");
`endif

endmodule

>>> design/bhs_dp.sv
// Datapath of the bucketed hash set: item registers, bucket index unit, bucket
// row memory with clearing pass, slot compare and result register.
// Depends on bhs_pkg and bhs_mod.
module bhs_dp import bhs_pkg::*; #(
    parameter int NUM_BUCKETS      = 19,
    parameter int SLOTS_PER_BUCKET = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic             i_in_action,
    input  logic [KEY_W-1:0] i_in_key,
    output logic             o_out_valid,
    output logic             o_out_ok,
    input  logic             i_out_ready
);

    localparam int BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int SW    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int ROW_W = SLOTS_PER_BUCKET * KEY_W;

    logic [ROW_W-1:0] r_mem [NUM_BUCKETS];

    logic             r_action;
    logic [KEY_W-1:0] r_key;
    logic [BW-1:0]    r_clr_cnt;
    logic [ROW_W-1:0] r_rd_row;
    logic [ROW_W-1:0] r_new_row;
    logic             r_ok;
    logic             r_we;
    logic             r_out_valid;
    logic             r_out_ok;

    logic [BW-1:0]    bucket;
    logic             mod_last;
    logic [KEY_W-1:0] slot;
    logic             hit_any;
    logic             hit_empty;
    logic [SW-1:0]    hit_idx;
    logic [ROW_W-1:0] n_new_row;
    logic             n_ok;
    logic             n_we;
    logic [BW-1:0]    wr_addr;
    logic [ROW_W-1:0] wr_data;
    logic             mem_we;

    bhs_mod #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.load_item),
        .i_step  (i_cmd.mod_step),
        .i_value ({{KEY_SHIFT{1'b0}}, i_in_key[KEY_W-1:KEY_SHIFT]}),
        .o_last  (mod_last),
        .o_rem   (bucket)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_action <= i_in_action;
            r_key    <= i_in_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    always_comb begin
        hit_any   = 1'b0;
        hit_empty = 1'b0;
        hit_idx   = '0;
        slot      = '0;
        for (int s = SLOTS_PER_BUCKET - 1; s >= 0; s--) begin
            slot = r_rd_row[s*KEY_W +: KEY_W];
            if (slot == '0 || slot == r_key) begin
                hit_any   = 1'b1;
                hit_empty = (slot == '0);
                hit_idx   = SW'(s);
            end
        end
        n_new_row = r_rd_row;
        for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
            if (SW'(s) == hit_idx) begin
                n_new_row[s*KEY_W +: KEY_W] = r_key;
            end
        end
        if (r_key == '0) begin
            n_ok = (r_action == ACT_INSERT);
            n_we = 1'b0;
        end else if (!hit_any) begin
            n_ok = 1'b0;
            n_we = 1'b0;
        end else if (hit_empty) begin
            n_ok = (r_action == ACT_INSERT);
            n_we = (r_action == ACT_INSERT);
        end else begin
            n_ok = 1'b1;
            n_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp_en) begin
            r_ok      <= n_ok;
            r_we      <= n_we;
            r_new_row <= n_new_row;
        end
    end

    assign mem_we  = i_cmd.clr_en || (i_cmd.wr_en && r_we);
    assign wr_addr = i_cmd.clr_en ? r_clr_cnt : bucket;
    assign wr_data = i_cmd.clr_en ? '0 : r_new_row;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_row <= r_mem[bucket];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_ok <= r_ok;
        end
    end

    assign o_sts.clr_last = (r_clr_cnt == BW'(NUM_BUCKETS - 1));
    assign o_sts.mod_last = mod_last;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_ok       = r_out_ok;

`ifndef SYNTHESIS
    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("A pending result beat was overwritten.");

    a_store_only_on_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_en && r_we) |-> (r_action == ACT_INSERT && r_key != '0))
        else $error("Table write for a test or for the empty key.");

    a_clear_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_en |-> !(i_cmd.wr_en || i_cmd.rd_en || i_cmd.load_item))
        else $error("Item activity during the clearing pass.");
`endif

endmodule

>>> design/bhs_ctrl.sv
// Controller of the bucketed hash set: sequences the clearing pass and the
// index, read, compare, write and result steps of each item. Depends on bhs_pkg.
module bhs_ctrl import bhs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_last) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp_en = 1'b1;
                n_state      = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.wr_en = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_write_after_compare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_en |-> $past(o_cmd.cmp_en))
        else $error("Table write without a preceding slot compare.");
`endif

endmodule
